/* rtl/core/itda_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itda_pkg
// Shared widths, character codes and handoff type for the integer to
// decimal text converter.
// ----------------------------------------------------------------------------
package itda_pkg;

  // Input integer width (two's complement)
  localparam int VALUE_WIDTH = 32;

  // Decimal digits of the largest magnitude, 2^(VALUE_WIDTH-1)
  localparam int NUM_DIGITS = ((VALUE_WIDTH - 1) * 30103) / 100000 + 1;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int BIT_CNT_W  = $clog2(VALUE_WIDTH);
  localparam int DIG_CNT_W  = $clog2(NUM_DIGITS);

  // ASCII codes
  localparam logic [7:0] CHAR_MINUS = 8'd45;
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;

  // Converted number handed from the BCD converter to the emitter
  typedef struct packed {
    logic [BCD_W-1:0] digits;
    logic             neg;
  } itda_bcd_t;

endpackage

/* rtl/core/itda_ifs.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itda_ifs
// Valid/ready channels: integer items in, character items out.
// ----------------------------------------------------------------------------
interface itda_in_if
  import itda_pkg::*;
  ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface itda_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last;

  modport source (output valid, output char_code, output last, input ready);
  modport sink   (input valid, input char_code, input last, output ready);
endinterface

/* rtl/core/itda_bcd_conv.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itda_bcd_conv
// Bit-serial binary to BCD converter (shift and add 3), one magnitude bit
// per cycle; holds the result until the emitter takes it.
// ----------------------------------------------------------------------------
module itda_bcd_conv
  import itda_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  itda_in_if.sink   in_ch,
  output logic      res_valid,
  input  logic      res_ready,
  output itda_bcd_t res
);

  logic                   run_r,  run_nxt;
  logic                   hold_r, hold_nxt;
  logic [BIT_CNT_W-1:0]   cnt_r,  cnt_nxt;
  logic [VALUE_WIDTH-1:0] mag_r,  mag_nxt;
  logic [BCD_W-1:0]       bcd_r,  bcd_nxt;
  logic                   neg_r,  neg_nxt;
  logic [BCD_W-1:0]       bcd_adj;
  logic [VALUE_WIDTH-1:0] in_bits;
  logic                   accept;

  assign in_ch.ready = !run_r && !hold_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign in_bits     = in_ch.value;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
  end

  // Load, shift one bit, hand off
  always_comb begin
    run_nxt  = run_r;
    hold_nxt = hold_r;
    cnt_nxt  = cnt_r;
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    neg_nxt  = neg_r;
    if (accept) begin
      neg_nxt = in_bits[VALUE_WIDTH-1];
      mag_nxt = in_bits[VALUE_WIDTH-1] ? (~in_bits + 1'b1) : in_bits;
      bcd_nxt = '0;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      bcd_nxt = {bcd_adj[BCD_W-2:0], mag_r[VALUE_WIDTH-1]};
      mag_nxt = {mag_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == BIT_CNT_W'(VALUE_WIDTH - 1)) begin
        run_nxt  = 1'b0;
        hold_nxt = 1'b1;
      end
    end else if (hold_r && res_ready) begin
      hold_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      hold_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      hold_r <= hold_nxt;
    end
    cnt_r <= cnt_nxt;
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    neg_r <= neg_nxt;
  end

  assign res_valid  = hold_r;
  assign res.digits = bcd_r;
  assign res.neg    = neg_r;

endmodule

/* rtl/core/itda_char_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itda_char_emit
// Shifts BCD digits out most significant first, drops leading zeros,
// prefixes '-' and flags the final character.
// ----------------------------------------------------------------------------
module itda_char_emit
  import itda_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       num_valid,
  output logic       num_ready,
  input  itda_bcd_t  num,
  itda_out_if.source out_ch
);

  logic                 busy_r,  busy_nxt;
  logic                 neg_r,   neg_nxt;
  logic                 seen_r,  seen_nxt;
  logic [DIG_CNT_W-1:0] cnt_r,   cnt_nxt;
  logic [BCD_W-1:0]     bcd_r,   bcd_nxt;
  logic                 ovld_r,  ovld_nxt;
  logic [7:0]           ochar_r, ochar_nxt;
  logic                 olast_r, olast_nxt;
  logic [3:0]           top_dig;
  logic                 is_last;
  logic                 step;

  assign num_ready = !busy_r;
  assign top_dig   = bcd_r[BCD_W-1 -: 4];
  assign is_last   = (cnt_r == DIG_CNT_W'(NUM_DIGITS - 1));
  assign step      = busy_r && (!ovld_r || out_ch.ready);

  always_comb begin
    busy_nxt  = busy_r;
    neg_nxt   = neg_r;
    seen_nxt  = seen_r;
    cnt_nxt   = cnt_r;
    bcd_nxt   = bcd_r;
    ovld_nxt  = ovld_r && !out_ch.ready;
    ochar_nxt = ochar_r;
    olast_nxt = olast_r;
    if (!busy_r) begin
      // Take the next converted number
      if (num_valid) begin
        busy_nxt = 1'b1;
        neg_nxt  = num.neg;
        seen_nxt = 1'b0;
        cnt_nxt  = '0;
        bcd_nxt  = num.digits;
      end
    end else if (step) begin
      if (neg_r) begin
        // Sign goes first
        ovld_nxt  = 1'b1;
        ochar_nxt = CHAR_MINUS;
        olast_nxt = 1'b0;
        neg_nxt   = 1'b0;
      end else begin
        // Emit a digit unless it is a leading zero; keep the units digit
        if (top_dig != 4'd0 || seen_r || is_last) begin
          ovld_nxt  = 1'b1;
          ochar_nxt = CHAR_ZERO + {4'd0, top_dig};
          olast_nxt = is_last;
          seen_nxt  = 1'b1;
        end
        bcd_nxt = {bcd_r[BCD_W-5:0], 4'd0};
        cnt_nxt = cnt_r + 1'b1;
        if (is_last) begin
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ovld_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ovld_r <= ovld_nxt;
    end
    neg_r   <= neg_nxt;
    seen_r  <= seen_nxt;
    cnt_r   <= cnt_nxt;
    bcd_r   <= bcd_nxt;
    ochar_r <= ochar_nxt;
    olast_r <= olast_nxt;
  end

  assign out_ch.valid     = ovld_r;
  assign out_ch.char_code = ochar_r;
  assign out_ch.last      = olast_r;

endmodule

/* rtl/core/int_to_decimal_ascii.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// int_to_decimal_ascii
// Signed integer to decimal ASCII text, one character per output item.
// ----------------------------------------------------------------------------
//  channel  dir  payload                 items per number
//  in_ch    in   value (VALUE_WIDTH, s)  1
//  out_ch   out  char_code[7:0], last    1 .. NUM_DIGITS+1
//
//  Conversion shifts in one magnitude bit per cycle (shift-and-add-3
//  converter); emission takes NUM_DIGITS steps plus one for a sign.
//  Conversion of one number overlaps emission of the previous one.
//  Synchronous active-low reset clears run, hold, busy and valid flags; no number is kept.
//  A stalled output holds its character; the input stalls until the
//  converter is free again.
// ----------------------------------------------------------------------------
module int_to_decimal_ascii
  import itda_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  itda_in_if.sink    in_ch,
  itda_out_if.source out_ch
);

  logic      num_valid;
  logic      num_ready;
  itda_bcd_t num;

  itda_bcd_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .res_valid (num_valid),
    .res_ready (num_ready),
    .res       (num)
  );

  itda_char_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .num_valid (num_valid),
    .num_ready (num_ready),
    .num       (num),
    .out_ch    (out_ch)
  );

`ifndef ASSERT_OFF
  // Only a sign or a decimal digit leaves the block
  a_char_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.char_code == CHAR_MINUS) ||
                     ((out_ch.char_code >= CHAR_ZERO) && (out_ch.char_code <= CHAR_NINE)))
    else $error("output character is neither sign nor digit");

  // A sign never ends a number
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.char_code == CHAR_MINUS) |-> !out_ch.last)
    else $error("sign flagged as last character");

  // Accepting a number starts the converter, which then refuses input
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready right after an accepted item");
`endif

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Checks the signed integer to decimal text converter. Each integer sent is
// spelled out by a predictor into a queue of expected characters, and every
// character the block emits is compared with the oldest entry in that queue.
// Directed extremes come first, then random values spread over all digit
// counts, a back-to-back stretch without idling, a long output stall and more random values.
// ----------------------------------------------------------------------------
module tb
  import itda_pkg::*;
();

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } text_char_t;

  logic clk;
  logic rst_n;

  itda_in_if  in_if ();
  itda_out_if out_if ();

  int_to_decimal_ascii uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  // Characters still owed by the block, oldest first
  text_char_t chars_due[$];
  int         faults;
  bit         calm;
  bit         sink_held;

  // Clock: 10 ns period
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Spell out a value in decimal and queue its characters
  function automatic void spell_value(input logic signed [VALUE_WIDTH-1:0] v);
    logic [VALUE_WIDTH-1:0] mag;
    logic [7:0]             digits[$];
    logic                   neg;
    neg = v[VALUE_WIDTH-1];
    mag = neg ? (~v + 1'b1) : v;
    do begin
      digits.push_front(CHAR_ZERO + 8'(mag % 10));
      mag = mag / 10;
    end while (mag != 0);
    if (neg) begin
      chars_due.push_back('{char_code: CHAR_MINUS, last: 1'b0});
    end
    foreach (digits[i]) begin
      chars_due.push_back('{char_code: digits[i], last: (i == digits.size() - 1)});
    end
  endfunction

  // Random value: half the time a chosen digit count, else raw words, small values or edges
  function automatic logic signed [VALUE_WIDTH-1:0] rand_value();
    longint lo;
    longint hi;
    longint mag;
    int     n;
    bit     neg;
    neg = $urandom_range(0, 1);
    case ($urandom_range(0, 7))
      0, 1: return $urandom;
      2:    return $urandom_range(0, 40) - 20;
      3: begin
        if (neg) return -32'sd2147483648 + $urandom_range(0, 15);
        else return 32'sd2147483647 - $urandom_range(0, 15);
      end
      default: begin
        n  = $urandom_range(1, 10);
        lo = 1;
        repeat (n - 1) lo = lo * 10;
        hi = lo * 10 - 1;
        if (n == 1) lo = 0;
        if (hi > 64'd2147483647) hi = neg ? 64'd2147483648 : 64'd2147483647;
        mag = $urandom_range(32'(hi), 32'(lo));
        return neg ? VALUE_WIDTH'(-mag) : VALUE_WIDTH'(mag);
      end
    endcase
  endfunction

  // Offer one item, wait for the handshake, then predict its text
  task automatic send_value(input logic signed [VALUE_WIDTH-1:0] v);
    int gap;
    @(negedge clk);
    if (!calm && $urandom_range(0, 99) < 14) begin
      gap = $urandom_range(1, 6);
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.value <= v;
    do @(posedge clk); while (!in_if.ready);
    spell_value(v);
  endtask

  // Receiver: random idling unless held or calm
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (sink_held) begin
        out_if.ready <= 1'b0;
      end else if (calm) begin
        out_if.ready <= 1'b1;
      end else begin
        out_if.ready <= ($urandom_range(0, 99) >= 14);
      end
    end
  end

  // Compare each emitted character with the oldest expectation
  always @(posedge clk) begin
    text_char_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (chars_due.size() == 0) begin
        faults++;
        if (faults <= 10) begin
          $display("unexpected char: char_code=%0d last=%0b", out_if.char_code, out_if.last);
        end
      end else begin
        want = chars_due.pop_front();
        if (out_if.char_code !== want.char_code || out_if.last !== want.last) begin
          faults++;
          if (faults <= 10) begin
            $display("char mismatch: expected char_code=%0d last=%0b, got char_code=%0d last=%0b",
                     want.char_code, want.last, out_if.char_code, out_if.last);
          end
        end
      end
    end
  end

  // Extremes, zero, digit-count boundaries and bit patterns
  task automatic test_directed();
    send_value(0);
    send_value(1);
    send_value(-1);
    send_value(9);
    send_value(10);
    send_value(-9);
    send_value(-10);
    send_value(99);
    send_value(100);
    send_value(-100);
    send_value(999999999);
    send_value(1000000000);
    send_value(-1000000000);
    send_value(32'sd2147483647);
    send_value(-32'sd2147483647);
    send_value(-32'sd2147483648);
    send_value(32'sh55555555);
    send_value(32'shAAAAAAAA);
    send_value(123456789);
    send_value(-987654321);
    send_value(0);
    send_value(32'sd2147483647);
  endtask

  // Random values across all digit counts, with idling on both sides
  task automatic test_random_values(input int count);
    repeat (count) send_value(rand_value());
  endtask

  // Back-to-back items with no idling on either side
  task automatic test_back_to_back(input int count);
    calm = 1'b1;
    repeat (count) send_value(rand_value());
    calm = 1'b0;
  endtask

  // Hold the receiver off while items keep coming so the input stalls
  task automatic test_output_stall(input int count);
    fork
      begin
        sink_held = 1'b1;
        repeat (400) @(posedge clk);
        sink_held = 1'b0;
      end
      begin
        repeat (count) send_value(rand_value());
      end
    join
  endtask

  // Run limit
  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int waited;
    faults       = 0;
    calm         = 1'b0;
    sink_held    = 1'b0;
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.value  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_values(150);
    test_back_to_back(50);
    test_output_stall(30);
    test_random_values(100);

    @(negedge clk);
    in_if.valid <= 1'b0;

    // Drain outstanding characters, then allow for the block's latency
    waited = 0;
    while (chars_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (60) @(posedge clk);
    if (chars_due.size() != 0) begin
      faults++;
      $display("%0d expected chars never arrived", chars_due.size());
    end

    if (faults == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
